[hw/rtl/capture_frequency_meter_outlier_macros.svh]
// ----------------------------------------------------------------------------
// Capture frequency meter macros
// Assertion helpers for the top RTL file of the frequency meter.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_FREQUENCY_METER_OUTLIER_MACROS_SVH
`define CAPTURE_FREQUENCY_METER_OUTLIER_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, held off while reset is active
`define CFMO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define CFMO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CFMO_ASSERT(lbl, prop, msg)
`define CFMO_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/cfmo_pkg.sv]
// ----------------------------------------------------------------------------
// Capture frequency meter package
// Item types, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package cfmo_pkg;

    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned RATIO_W   = 16;
    localparam int unsigned LIMIT_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned DIV_STEPS = FIELD_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int unsigned PROD_W    = FIELD_W + RATIO_W;
    localparam int unsigned SUM_W     = FIELD_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_LIMIT = 2'd2;

    localparam logic [FIELD_W-1:0] CLOCK_HZ_RESET      = 32'd42000000;
    localparam logic [RATIO_W-1:0] OUTLIER_RATIO_RESET = 16'd2000;
    localparam logic [LIMIT_W-1:0] OUTLIER_LIMIT_RESET = 4'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] capture_value;
    } t_in_item;

    typedef struct packed {
        logic               pair_done;
        logic               calc_ok;
        logic [FIELD_W-1:0] measured_freq;
        logic [FIELD_W-1:0] current_freq;
        logic               is_outlier;
        logic               hold_off;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DEC,
        ST_OUT
    } t_state;

endpackage

[hw/rtl/cfmo_stream_if.sv]
// ----------------------------------------------------------------------------
// Capture frequency meter stream channel
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface cfmo_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/cfmo_divider.sv]
// ----------------------------------------------------------------------------
// Capture frequency meter divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfmo_divider #(
    parameter int unsigned W = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cfmo_pkg::FIELD_W-1:0] i_dividend,
    input  logic [W-1:0]                i_divisor,
    output logic                        o_done,
    output logic [cfmo_pkg::FIELD_W-1:0] o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [cfmo_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [W-1:0]                  r_rem;
    logic [W-1:0]                  r_divisor;
    logic [cfmo_pkg::FIELD_W-1:0]  r_quot;

    logic [W:0]   shifted;
    logic         q_bit;
    logic [W:0]   trial;
    logic [W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_quot[cfmo_pkg::FIELD_W-1]};
        trial   = shifted - {1'b0, r_divisor};
        q_bit   = (shifted >= {1'b0, r_divisor});
        n_rem   = q_bit ? trial[W-1:0] : shifted[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cfmo_pkg::DIV_CNT_W'(cfmo_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out of the top of the quotient register as bits come in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_quot    <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[cfmo_pkg::FIELD_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

[hw/rtl/cfmo_outlier.sv]
// ----------------------------------------------------------------------------
// Capture frequency meter outlier test
// Registered |meas - acc| * ratio against meas + acc: difference and sum, then product.
// ----------------------------------------------------------------------------
module cfmo_outlier (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [cfmo_pkg::FIELD_W-1:0] i_meas,
    input  logic [cfmo_pkg::FIELD_W-1:0] i_acc,
    input  logic [cfmo_pkg::RATIO_W-1:0] i_ratio,
    output logic                        o_far
);

    logic [cfmo_pkg::FIELD_W-1:0] r_diff;
    logic [cfmo_pkg::SUM_W-1:0]   r_sum;
    logic [cfmo_pkg::PROD_W-1:0]  r_prod;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diff <= (i_meas > i_acc) ? (i_meas - i_acc) : (i_acc - i_meas);
            r_sum  <= {1'b0, i_meas} + {1'b0, i_acc};
        end
        r_prod <= r_diff * i_ratio;
    end

    assign o_far = (r_prod > cfmo_pkg::PROD_W'(r_sum));

endmodule

[hw/rtl/capture_frequency_meter_outlier.sv]
// Opening capture, or closing capture with no positive period: result can be
// taken in the cycle after acceptance.
// Closing capture with a positive period: result can be taken after the divider
// steps, done flag, multiply, compare and output.
// One item at a time; the next is accepted the cycle after the result is taken.
// Synchronous active-low reset restores register defaults and clears the sequencer, pairing and filter state.
// ----------------------------------------------------------------------------
// Capture frequency meter with outlier rejection
// Pairs capture timestamps, divides the clock by the period and filters
// the frequency against the accepted value.
// ----------------------------------------------------------------------------
`include "capture_frequency_meter_outlier_macros.svh"

module capture_frequency_meter_outlier #(
    parameter int unsigned CAPTURE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cfmo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cfmo_pkg::CFG_W-1:0]     i_cfg_data,
    cfmo_stream_if.sink                   i_in,
    cfmo_stream_if.source                 o_out
);

    cfmo_pkg::t_state r_state, n_state;

    logic [cfmo_pkg::FIELD_W-1:0] r_clock_hz;
    logic [cfmo_pkg::RATIO_W-1:0] r_ratio;
    logic [cfmo_pkg::LIMIT_W-1:0] r_limit;

    logic                         r_have_first;
    logic [CAPTURE_WIDTH-1:0]     r_first;
    logic [cfmo_pkg::FIELD_W-1:0] r_acc;
    logic [cfmo_pkg::LIMIT_W-1:0] r_run;
    cfmo_pkg::t_out_item          r_res;

    logic                         in_acc;
    logic [CAPTURE_WIDTH-1:0]     cap;
    logic                         cap_gt;
    logic [CAPTURE_WIDTH-1:0]     period;
    logic                         div_start;
    logic                         div_done;
    logic [cfmo_pkg::FIELD_W-1:0] div_quot;
    logic                         far;
    logic [cfmo_pkg::LIMIT_W-1:0] run_inc;

    assign cap     = i_in.data.capture_value[CAPTURE_WIDTH-1:0];
    assign cap_gt  = (cap > r_first);
    assign period  = cap - r_first;
    assign in_acc  = i_in.valid && i_in.ready;
    assign run_inc = r_run + 1'b1;

    cfmo_divider #(
        .W (CAPTURE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_clock_hz),
        .i_divisor  (period),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    cfmo_outlier u_outlier (
        .i_clk   (i_clk),
        .i_load  (div_done),
        .i_meas  (div_quot),
        .i_acc   (r_acc),
        .i_ratio (r_ratio),
        .o_far   (far)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfmo_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (r_have_first && cap_gt) ? cfmo_pkg::ST_DIV : cfmo_pkg::ST_OUT;
                end
            end
            cfmo_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = cfmo_pkg::ST_MUL;
                end
            end
            cfmo_pkg::ST_MUL: n_state = cfmo_pkg::ST_DEC;
            cfmo_pkg::ST_DEC: n_state = cfmo_pkg::ST_OUT;
            cfmo_pkg::ST_OUT: begin
                if (o_out.ready) begin
                    n_state = cfmo_pkg::ST_IDLE;
                end
            end
            default: n_state = cfmo_pkg::ST_IDLE;
        endcase
    end

    // Handshake and unit control
    always_comb begin
        i_in.ready  = (r_state == cfmo_pkg::ST_IDLE);
        o_out.valid = (r_state == cfmo_pkg::ST_OUT);
        o_out.data  = r_res;
        div_start   = (r_state == cfmo_pkg::ST_IDLE) && i_in.valid && r_have_first && cap_gt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfmo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= cfmo_pkg::CLOCK_HZ_RESET;
            r_ratio    <= cfmo_pkg::OUTLIER_RATIO_RESET;
            r_limit    <= cfmo_pkg::OUTLIER_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cfmo_pkg::CFG_CLOCK_HZ:      r_clock_hz <= i_cfg_data;
                cfmo_pkg::CFG_OUTLIER_RATIO: r_ratio    <= i_cfg_data[cfmo_pkg::RATIO_W-1:0];
                cfmo_pkg::CFG_OUTLIER_LIMIT: r_limit    <= i_cfg_data[cfmo_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_first      <= '0;
            r_acc        <= '0;
            r_run        <= '0;
        end else begin
            if (in_acc) begin
                r_have_first <= !r_have_first;
                if (!r_have_first) begin
                    r_first <= cap;
                end
            end
            if (r_state == cfmo_pkg::ST_DEC) begin
                priority if (r_acc == '0) begin
                    r_acc <= div_quot;
                end else if (far) begin
                    r_run <= (run_inc >= r_limit) ? '0 : run_inc;
                end else begin
                    r_run <= '0;
                    r_acc <= div_quot;
                end
            end
        end
    end

    // Result register: filled on acceptance when no divide is needed, else at decision
    always_ff @(posedge i_clk) begin
        if (in_acc && !div_start) begin
            r_res.pair_done     <= r_have_first;
            r_res.calc_ok       <= 1'b0;
            r_res.measured_freq <= '0;
            r_res.current_freq  <= r_acc;
            r_res.is_outlier    <= 1'b0;
            r_res.hold_off      <= 1'b0;
        end else if (r_state == cfmo_pkg::ST_DEC) begin
            r_res.pair_done     <= 1'b1;
            r_res.calc_ok       <= 1'b1;
            r_res.measured_freq <= div_quot;
            r_res.is_outlier    <= (r_acc != '0) && far;
            r_res.hold_off      <= (r_acc != '0) && far && (run_inc >= r_limit);
            if ((r_acc == '0) || !far) begin
                r_res.current_freq <= div_quot;
            end else begin
                r_res.current_freq <= r_acc;
            end
        end
    end

    `CFMO_ASSERT(a_div_start_nonzero, div_start |-> (period != '0), "divide started with zero period")
    `CFMO_ASSERT(a_done_in_div, div_done |-> (r_state == cfmo_pkg::ST_DIV), "divider done outside divide state")
    `CFMO_ASSERT(a_pair_closes, (in_acc && r_have_first) |=> !r_have_first, "pair not closed")
    `CFMO_ASSERT(a_hold_needs_outlier, (o_out.valid && o_out.data.hold_off) |-> (o_out.data.is_outlier && o_out.data.calc_ok), "hold-off without outlier")
    `CFMO_ASSERT(a_one_side, !(i_in.ready && o_out.valid), "input open while result pending")

endmodule

[test/capture_frequency_meter_outlier_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frequency meter result checker
// Watches the capture and result channels and the register port, predicts
// every reading from its own copy of the meter state and compares results
// in order.
// ----------------------------------------------------------------------------
module capture_frequency_meter_outlier_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfmo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cfmo_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_cap_valid,
    input  logic                           i_cap_ready,
    input  cfmo_pkg::t_in_item             i_cap_item,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  cfmo_pkg::t_out_item            i_res_item,
    output int                             o_fail_count,
    output int                             o_pending
);
    import cfmo_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [FIELD_W-1:0] clock_hz_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic               have_first;
    logic [FIELD_W-1:0] first_capture;
    logic [FIELD_W-1:0] accepted_freq;
    logic [LIMIT_W-1:0] outlier_run;

    t_out_item expected_readings[$];
    int        error_count;

    // Work out the reading for one capture and advance the meter state
    function automatic t_out_item predict_reading(logic [FIELD_W-1:0] cap);
        t_out_item          r;
        logic [FIELD_W-1:0] period;
        logic [63:0]        diff;
        logic [63:0]        total;
        r = '0;
        if (!have_first) begin
            first_capture = cap;
            have_first    = 1'b1;
        end else begin
            r.pair_done = 1'b1;
            if (cap > first_capture) begin
                period          = cap - first_capture;
                r.measured_freq = clock_hz_reg / period;
                r.calc_ok       = 1'b1;
                if (accepted_freq == '0) begin
                    accepted_freq = r.measured_freq;
                end else begin
                    diff  = (r.measured_freq > accepted_freq) ?
                            64'(r.measured_freq - accepted_freq) :
                            64'(accepted_freq - r.measured_freq);
                    total = 64'(accepted_freq) + 64'(r.measured_freq);
                    if (diff * 64'(ratio_reg) > total) begin
                        r.is_outlier = 1'b1;
                        outlier_run  = outlier_run + 1'b1;
                        if (outlier_run >= limit_reg) begin
                            outlier_run = '0;
                            r.hold_off  = 1'b1;
                        end
                    end else begin
                        outlier_run   = '0;
                        accepted_freq = r.measured_freq;
                    end
                end
            end
            have_first = 1'b0;
        end
        r.current_freq = accepted_freq;
        return r;
    endfunction

    task automatic report_failure(input string what, input t_out_item exp_r,
                                  input t_out_item got_r);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected pair=%0d ok=%0d meas=%0d cur=%0d outl=%0d hold=%0d",
                     exp_r.pair_done, exp_r.calc_ok, exp_r.measured_freq,
                     exp_r.current_freq, exp_r.is_outlier, exp_r.hold_off);
            $display("  actual   pair=%0d ok=%0d meas=%0d cur=%0d outl=%0d hold=%0d",
                     got_r.pair_done, got_r.calc_ok, got_r.measured_freq,
                     got_r.current_freq, got_r.is_outlier, got_r.hold_off);
        end
    endtask

    initial begin
        error_count = 0;
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            clock_hz_reg  = CLOCK_HZ_RESET;
            ratio_reg     = OUTLIER_RATIO_RESET;
            limit_reg     = OUTLIER_LIMIT_RESET;
            have_first    = 1'b0;
            first_capture = '0;
            accepted_freq = '0;
            outlier_run   = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLOCK_HZ:      clock_hz_reg = i_cfg_data[FIELD_W-1:0];
                    CFG_OUTLIER_RATIO: ratio_reg    = i_cfg_data[RATIO_W-1:0];
                    CFG_OUTLIER_LIMIT: limit_reg    = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cap_valid && i_cap_ready)
                expected_readings.push_back(predict_reading(i_cap_item.capture_value));
            if (i_res_valid && i_res_ready) begin
                if (expected_readings.size() == 0) begin
                    report_failure("result with nothing expected", '0, i_res_item);
                end else begin
                    exp_r = expected_readings.pop_front();
                    if (i_res_item.pair_done     !== exp_r.pair_done     ||
                        i_res_item.calc_ok       !== exp_r.calc_ok       ||
                        i_res_item.measured_freq !== exp_r.measured_freq ||
                        i_res_item.current_freq  !== exp_r.current_freq  ||
                        i_res_item.is_outlier    !== exp_r.is_outlier    ||
                        i_res_item.hold_off      !== exp_r.hold_off)
                        report_failure("reading mismatch", exp_r, i_res_item);
                end
            end
        end
        o_fail_count <= error_count;
        o_pending    <= expected_readings.size();
    end

endmodule

[test/capture_frequency_meter_outlier_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frequency meter testbench
// Drives capture timestamps in pairs through directed cases and several
// register settings, stalls both channels at random and leaves the checking
// to the result checker beside the meter.
// ----------------------------------------------------------------------------
module capture_frequency_meter_outlier_tb;
    import cfmo_pkg::*;

    localparam int IDLE_PCT        = 9;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int DRAIN_CYCLES    = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int   fail_count;
    int   pending;
    int   sent_count;
    logic pair_open;
    logic quiet;
    logic rx_hold;

    cfmo_stream_if #(.T(t_in_item))  cap_ch ();
    cfmo_stream_if #(.T(t_out_item)) res_ch ();

    capture_frequency_meter_outlier uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (cap_ch),
        .o_out       (res_ch)
    );

    capture_frequency_meter_outlier_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_cap_valid  (cap_ch.valid),
        .i_cap_ready  (cap_ch.ready),
        .i_cap_item   (cap_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_item   (res_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("capture_frequency_meter_outlier test failed");
        $finish;
    end

    // Result side: random stalls, or one long hold when asked
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold && !hold_done) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                res_ch.ready <= quiet || ($urandom_range(99, 0) >= IDLE_PCT);
            end
        end
    end

    task automatic send_capture(input logic [FIELD_W-1:0] cap);
        while (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
            cap_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cap_ch.valid <= 1'b1;
        cap_ch.data  <= t_in_item'(cap);
        do @(posedge i_clk); while (!cap_ch.ready);
        pair_open = ~pair_open;
        sent_count++;
    endtask

    // Close any open pair with a random capture first, so the pair lines up
    task automatic send_pair(input logic [FIELD_W-1:0] first, input logic [FIELD_W-1:0] second);
        if (pair_open)
            send_capture($urandom);
        send_capture(first);
        send_capture(second);
    endtask

    task automatic send_period(input int unsigned period);
        int unsigned first;
        first = $urandom_range(32'hFFFF_FFFF - period, 0);
        send_pair(first, first + period);
    endtask

    task automatic wait_drained();
        cap_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [FIELD_W-1:0] hz, input logic [RATIO_W-1:0] ratio,
                              input logic [LIMIT_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CLOCK_HZ;
        cfg_data  <= hz;
        @(posedge i_clk);
        cfg_index <= CFG_OUTLIER_RATIO;
        cfg_data  <= CFG_W'(ratio);
        @(posedge i_clk);
        cfg_index <= CFG_OUTLIER_LIMIT;
        cfg_data  <= CFG_W'(limit);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int unsigned        base;
        int unsigned        period;
        int unsigned        first;
        int unsigned        second;
        int unsigned        r;
        int                 phase_start;
        logic               held;
        logic [FIELD_W-1:0] hz;
        logic [RATIO_W-1:0] ratio;
        logic [LIMIT_W-1:0] limit;

        pair_open  = 1'b0;
        sent_count = 0;
        quiet      = 1'b0;
        rx_hold    = 1'b0;
        held       = 1'b0;
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_CLOCK_HZ;
        cfg_data     <= '0;
        cap_ch.valid <= 1'b0;
        cap_ch.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero reading with nothing accepted, then first acceptance
        send_pair(32'h0000_0000, 32'hFFFF_FFFF);
        send_pair(32'd0, 32'd42000);
        send_pair(32'd100, 32'd42100);
        // equal stamps, then a timer wrap
        send_pair(32'd5, 32'd5);
        send_pair(32'hFFFF_FFF0, 32'h0000_0010);
        // two outliers in a row reach the default limit
        send_pair(32'd0, 32'd84000);
        send_pair(32'd10, 32'd20);
        send_pair(32'd3, 32'd42003);
        wait_drained();
        // build a run under a high limit, then lower the limit beneath it
        write_regs(CLOCK_HZ_RESET, OUTLIER_RATIO_RESET, 4'd15);
        repeat (3) send_pair(32'd0, 32'd10);
        wait_drained();
        write_regs(CLOCK_HZ_RESET, OUTLIER_RATIO_RESET, 4'd2);
        send_pair(32'd0, 32'd10);
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin hz = CLOCK_HZ_RESET; ratio = OUTLIER_RATIO_RESET;
                         limit = OUTLIER_LIMIT_RESET; end
                1: begin hz = 32'd1;        ratio = 16'd1;     limit = 4'd1;  end
                2: begin hz = '1;           ratio = '1;        limit = 4'd15; end
                3: begin hz = '0;           ratio = '0;        limit = 4'd1;  end
                4: begin hz = 32'd100000000; ratio = 16'd20;   limit = 4'd3;  end
                6: begin hz = 32'd10000000; ratio = 16'd4;     limit = 4'd0;  end
                default: begin
                    hz    = $urandom;
                    ratio = RATIO_W'($urandom);
                    limit = LIMIT_W'($urandom);
                end
            endcase
            quiet = (ph == 2);
            base  = ($urandom_range(9, 0) == 0) ? $urandom_range(1 << 20, 1)
                                                : $urandom_range(4096, 1);
            // anchor the accepted frequency: a ratio of one rejects nothing
            write_regs(hz, 16'd1, limit);
            send_period(base);
            wait_drained();
            write_regs(hz, ratio, limit);

            phase_start = sent_count;
            while (sent_count - phase_start < ITEMS_PER_PHASE) begin
                if (ph == 4 && !held && sent_count - phase_start >= 20) begin
                    rx_hold = 1'b1;
                    held    = 1'b1;
                end
                if (ph == 5 && sent_count - phase_start == 30)
                    wait_drained();
                r = $urandom_range(99, 0);
                if (r < 3) begin
                    // stray capture: shifts the pairing
                    send_capture($urandom);
                end else if (r < 10) begin
                    repeat ($urandom_range(16, 1))
                        send_period(base * 4 + $urandom_range(base, 0));
                end else begin
                    r = $urandom_range(99, 0);
                    if (r < 55)      period = base;
                    else if (r < 72) period = base - base / 16 + $urandom_range(base / 8 + 1, 0);
                    else if (r < 82) period = base * 4 + $urandom_range(base, 0);
                    else if (r < 86) period = 1;
                    else             period = 0;
                    first  = $urandom_range(32'hFFFF_FFFF - period, 0);
                    second = first + period;
                    if (r >= 94)
                        second = $urandom_range(first, 0);
                    if (r >= 97) begin
                        first  = $urandom;
                        second = $urandom;
                    end
                    send_pair(first, second);
                end
            end
            wait_drained();
        end
        quiet = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("capture_frequency_meter_outlier test passed");
        else
            $display("capture_frequency_meter_outlier test failed");
        $finish;
    end

endmodule
